[hw/rtl/swm_pkg.sv]
package swm_pkg;

    localparam int WINDOW_MAX  = 1024;
    localparam int SAMPLE_BITS = 32;
    localparam int LEN_BITS    = 11;
    localparam int SLOT_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);

    typedef struct packed {
        logic                   v;
        logic [SAMPLE_BITS-1:0] d;
        logic [SLOT_BITS-1:0]   a;
    } t_entry;

    typedef struct packed {
        logic                   clr;
        logic                   ins;
        logic                   shift;
        logic [SAMPLE_BITS-1:0] x;
        logic [CNT_BITS-1:0]    len;
    } t_ctl;

    // zero acts as one, values past the store depth saturate
    function automatic logic [CNT_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] len);
        int unsigned n;
        n = 32'(len);
        if (n == 0) begin
            n = 1;
        end
        if (n > WINDOW_MAX) begin
            n = WINDOW_MAX;
        end
        return CNT_BITS'(n);
    endfunction

endpackage

[hw/rtl/swm_cell.sv]
module swm_cell import swm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctl   i_ctl,
    input  t_entry i_next,
    input  logic   i_next_keep,
    input  logic   i_prev_keep,
    output t_entry o_entry,
    output t_entry o_entry_nxt,
    output logic   o_keep,
    output logic   o_keep_shift
);

    t_entry              r_entry;
    t_entry              n_entry;
    t_entry              w_src;
    logic                w_src_keep;
    logic [CNT_BITS-1:0] w_age_inc;

    assign w_age_inc = CNT_BITS'(r_entry.a) + CNT_BITS'(1);

    // survives if older and strictly smaller than the incoming sample, and still in window
    assign o_keep = r_entry.v
                 && ($signed(r_entry.d) < $signed(i_ctl.x))
                 && (w_age_inc < i_ctl.len);

    assign w_src        = i_ctl.shift ? i_next : r_entry;
    assign w_src_keep   = i_ctl.shift ? i_next_keep : o_keep;
    assign o_keep_shift = w_src_keep;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.clr) begin
            n_entry.v = 1'b0;
        end else if (i_ctl.ins) begin
            if (w_src_keep) begin
                n_entry   = w_src;
                n_entry.a = w_src.a + SLOT_BITS'(1);
            end else if (i_prev_keep) begin
                n_entry.v = 1'b1;
                n_entry.d = i_ctl.x;
                n_entry.a = '0;
            end else begin
                n_entry.v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.v <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry     = r_entry;
    assign o_entry_nxt = n_entry;

endmodule

[hw/rtl/sliding_window_minimum.sv]
// Sliding window minimum over a signed sample stream.
// Input channel: i_valid / o_ready with i_sample. Output channel: o_valid /
// i_ready with o_window_min, one result per request, in order.
// The minimum is kept in a chain of WINDOW_MAX cells forming a monotonic
// queue: each cell compares its entry with the new sample, drops it or hands
// it to its neighbor, and the front cell holds the minimum outside a replay.
// Results show in the cycle after acceptance; one request per cycle outside
// a replay; the single output register refills in the cycle it is taken.
// When the receiver stalls, o_ready stays low until the result is taken.
// Writing window_len (i_cfg_we) clears the chain and replays the last
// min(effective window_len, samples seen) samples from the sample memory,
// one per cycle; o_ready is low until the last replayed sample is in the
// chain, or not at all when no sample has been seen yet.
// Reset (i_rst_n low at a clock edge) empties the chain and the output
// register, sets window_len to 1 and forgets all samples seen so far;
// o_ready is low while i_rst_n is low.
module sliding_window_minimum import swm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_window_min,
    input  logic                   i_cfg_we,
    input  logic [LEN_BITS-1:0]    i_window_len
);

    logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

    logic [CNT_BITS-1:0]    r_leff;
    logic [CNT_BITS-1:0]    r_fill;
    logic [SLOT_BITS-1:0]   r_wr_slot;
    logic [CNT_BITS-1:0]    r_rb_cnt;
    logic [SLOT_BITS-1:0]   r_rd_slot;
    logic                   r_rd_v;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_out_v;
    logic [SAMPLE_BITS-1:0] r_out;

    logic                   w_accept;
    logic                   w_busy;
    logic [CNT_BITS-1:0]    w_cfg_len;
    logic [CNT_BITS-1:0]    w_rb_n;
    logic [CNT_BITS:0]      w_start_sum;
    logic [SLOT_BITS-1:0]   w_start;
    logic [CNT_BITS-1:0]    w_front_age_inc;
    t_ctl                   w_ctl;

    t_entry w_entry     [WINDOW_MAX];
    t_entry w_entry_nxt [WINDOW_MAX];
    logic   w_keep      [WINDOW_MAX];
    logic   w_keep_sh   [WINDOW_MAX];

    assign w_busy   = (r_rb_cnt != '0) || r_rd_v;
    assign o_ready  = i_rst_n && !w_busy && (!r_out_v || i_ready);
    assign w_accept = i_valid && o_ready;

    assign w_cfg_len   = eff_len(i_window_len);
    assign w_rb_n      = (w_cfg_len < r_fill) ? w_cfg_len : r_fill;
    assign w_start_sum = (CNT_BITS+1)'(r_wr_slot) + (CNT_BITS+1)'(WINDOW_MAX)
                       - (CNT_BITS+1)'(w_rb_n);
    assign w_start     = (w_start_sum >= (CNT_BITS+1)'(WINDOW_MAX))
                       ? SLOT_BITS'(w_start_sum - (CNT_BITS+1)'(WINDOW_MAX))
                       : SLOT_BITS'(w_start_sum);

    assign w_front_age_inc = CNT_BITS'(w_entry[0].a) + CNT_BITS'(1);

    always_comb begin
        w_ctl.clr   = i_cfg_we;
        w_ctl.ins   = w_accept || r_rd_v;
        w_ctl.shift = w_entry[0].v && (w_front_age_inc >= r_leff);
        w_ctl.x     = r_rd_v ? r_rd_data : i_sample;
        w_ctl.len   = r_leff;
    end

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        t_entry w_nb;
        logic   w_nb_keep;
        logic   w_pv_keep;

        if (g == WINDOW_MAX - 1) begin : g_last
            assign w_nb      = '0;
            assign w_nb_keep = 1'b0;
        end else begin : g_mid
            assign w_nb      = w_entry[g+1];
            assign w_nb_keep = w_keep[g+1];
        end

        if (g == 0) begin : g_front
            assign w_pv_keep = 1'b1;
        end else begin : g_rest
            assign w_pv_keep = w_keep_sh[g-1];
        end

        swm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_next       (w_nb),
            .i_next_keep  (w_nb_keep),
            .i_prev_keep  (w_pv_keep),
            .o_entry      (w_entry[g]),
            .o_entry_nxt  (w_entry_nxt[g]),
            .o_keep       (w_keep[g]),
            .o_keep_shift (w_keep_sh[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            mem[r_wr_slot] <= i_sample;
        end
        if (!i_cfg_we && r_rb_cnt != '0) begin
            r_rd_data <= mem[r_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leff    <= CNT_BITS'(1);
            r_fill    <= '0;
            r_wr_slot <= '0;
            r_rb_cnt  <= '0;
            r_rd_slot <= '0;
            r_rd_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_wr_slot <= (r_wr_slot == SLOT_BITS'(WINDOW_MAX - 1))
                           ? '0 : r_wr_slot + SLOT_BITS'(1);
                if (r_fill != CNT_BITS'(WINDOW_MAX)) begin
                    r_fill <= r_fill + CNT_BITS'(1);
                end
            end

            if (i_cfg_we) begin
                r_leff    <= w_cfg_len;
                r_rb_cnt  <= w_rb_n;
                r_rd_slot <= w_start;
                r_rd_v    <= 1'b0;
            end else if (r_rb_cnt != '0) begin
                r_rb_cnt  <= r_rb_cnt - CNT_BITS'(1);
                r_rd_slot <= (r_rd_slot == SLOT_BITS'(WINDOW_MAX - 1))
                           ? '0 : r_rd_slot + SLOT_BITS'(1);
                r_rd_v    <= 1'b1;
            end else begin
                r_rd_v    <= 1'b0;
            end

            if (w_accept) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_entry_nxt[0].d;
        end
    end

    assign o_valid      = r_out_v;
    assign o_window_min = r_out;

    // queue order: front is oldest and strictly smallest
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry[1].v |-> (w_entry[0].v
                          && ($signed(w_entry[0].d) < $signed(w_entry[1].d))
                          && (w_entry[0].a > w_entry[1].a)))
        else $error("cell chain out of order");

    a_front_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry[0].v |-> (CNT_BITS'(w_entry[0].a) < r_leff))
        else $error("front entry outside window");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> !w_entry[0].v)
        else $error("chain holds data before any sample");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_cfg_we) |=> (o_valid && o_window_min == w_entry[0].d))
        else $error("result differs from front cell");

endmodule

[tb/tb_top.sv]
module tb_top import swm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 37;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 120;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum int {
        STYLE_NOISE,
        STYLE_RISING,
        STYLE_FALLING,
        STYLE_NARROW
    } t_style;

    // Expected minimum per request, from a copy of the sample history.
    class window_min_board;
        logic signed [SAMPLE_BITS-1:0] history [WINDOW_MAX];
        logic signed [SAMPLE_BITS-1:0] pending_mins [$];
        logic [LEN_BITS-1:0]           len_reg;
        int unsigned                   next_slot;
        int unsigned                   filled;
        int unsigned                   mismatches;
        int unsigned                   checked;

        function new();
            foreach (history[i]) history[i] = SMP_MAX;
            len_reg    = LEN_BITS'(1);
            next_slot  = 0;
            filled     = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_len(logic [LEN_BITS-1:0] v);
            len_reg = v;
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
            int unsigned newest;
            int unsigned span;
            int unsigned slot;
            logic signed [SAMPLE_BITS-1:0] best;
            newest = next_slot;
            history[newest] = s;
            next_slot = (newest + 1) % WINDOW_MAX;
            if (filled < WINDOW_MAX) filled++;
            span = (len_reg == 0) ? 1 : int'(len_reg);
            if (span > WINDOW_MAX) span = WINDOW_MAX;
            if (span > filled) span = filled;
            best = SMP_MAX;
            for (int unsigned k = 0; k < span; k++) begin
                slot = (newest + WINDOW_MAX - k) % WINDOW_MAX;
                if (history[slot] < best) best = history[slot];
            end
            pending_mins = {pending_mins, best};
        endfunction

        function void check_min(logic signed [SAMPLE_BITS-1:0] got);
            logic signed [SAMPLE_BITS-1:0] want;
            checked++;
            if (pending_mins.size() == 0) begin
                $error("window_min: no request pending, actual %0d", got);
                mismatches++;
            end else begin
                want = pending_mins.pop_front();
                if (got !== want) begin
                    $error("window_min: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned waiting();
            return pending_mins.size();
        endfunction
    endclass

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_valid      = 1'b0;
    logic [SAMPLE_BITS-1:0] i_sample     = '0;
    logic                   i_ready      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [LEN_BITS-1:0]    i_window_len = '0;
    logic                   o_ready;
    logic                   o_valid;
    logic [SAMPLE_BITS-1:0] o_window_min;

    window_min_board board = new();

    logic        steady     = 1'b0;
    logic        want_hold  = 1'b0;
    logic        hold_done  = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned cycles     = 0;
    int unsigned samples_in = 0;
    int unsigned len_writes = 0;

    sliding_window_minimum DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_window_min (o_window_min),
        .i_cfg_we     (i_cfg_we),
        .i_window_len (i_window_len)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("sliding_window_minimum verification failed");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_min(o_window_min);
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (want_hold && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic offer(logic signed [SAMPLE_BITS-1:0] s);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        board.note_sample(s);
        samples_in++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.waiting() != 0) @(posedge i_clk);
    endtask

    task automatic write_len(logic [LEN_BITS-1:0] v);
        drain();
        i_cfg_we     <= 1'b1;
        i_window_len <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_len(v);
        len_writes++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(t_style style,
            int unsigned idx, logic signed [SAMPLE_BITS-1:0] base, int step);
        logic signed [SAMPLE_BITS-1:0] s;
        case (style)
            STYLE_RISING:  s = base + SAMPLE_BITS'(idx * step);
            STYLE_FALLING: s = base - SAMPLE_BITS'(idx * step);
            STYLE_NARROW:  s = SAMPLE_BITS'($urandom_range(0, 15)) - 8;
            default: begin
                case ($urandom_range(0, 15))
                    0:       s = SMP_MAX;
                    1:       s = SMP_MIN;
                    default: s = $urandom;
                endcase
            end
        endcase
        return s;
    endfunction

    initial begin
        logic [LEN_BITS-1:0]           lens [10];
        logic signed [SAMPLE_BITS-1:0] base;
        t_style                        style;
        int                            step;

        lens = '{11'd3, 11'd1, 11'd17, 11'd1024, 11'd0, 11'd2047, 11'd1025,
                 11'd0, 11'd64, 11'd1024};
        lens[7] = LEN_BITS'($urandom_range(0, 2047));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window length of one: result follows the sample
        offer(SMP_MAX);
        offer(SMP_MIN);
        offer(0);
        offer(-1);
        offer(1);
        // zero length acts as one
        write_len(LEN_BITS'(0));
        offer(5);
        offer(-7);
        offer(6);
        // short window: old minimum ages out
        write_len(LEN_BITS'(4));
        foreach (lens[i]) offer(10 - i);
        offer(20);
        offer(30);
        offer(40);
        offer(50);
        // length beyond the store saturates
        write_len(LEN_BITS'(2047));
        offer(SMP_MAX);
        offer(SMP_MIN);
        offer(3);
        offer(4);

        for (int p = 0; p < 10; p++) begin
            write_len(lens[p]);
            steady <= (p == 2);
            if (p == 4) want_hold <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 30 == 0) begin
                    style = t_style'($urandom_range(0, 3));
                    base  = $urandom;
                    step  = $urandom_range(1, 1000);
                end
                offer(pick_sample(style, n % 30, base, step));
            end
        end

        steady <= 1'b0;
        drain();
        repeat (4) @(posedge i_clk);

        $display("run covered %0d samples over %0d window length writes, store wrapped %0d times",
                 samples_in, len_writes, samples_in / WINDOW_MAX);
        $display("%0d results compared, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0) begin
            $display("sliding_window_minimum verification clean");
        end else begin
            $display("sliding_window_minimum verification failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/sliding_window_minimum.sv
tb/tb_top.sv
